// ----- rtl/pci_pkg.sv -----
// Shared types and constants for the clamped-integral PID controller.
// No dependencies; every module of the block imports this package.
package pci_pkg;

  localparam int GAIN_W          = 32;
  localparam int LIM_W           = 9;
  localparam int MEAS_WIDTH_DEF  = 24;
  localparam int FRAC_BITS_DEF   = 24;
  localparam int CFG_IDX_W       = 3;

  localparam logic [GAIN_W-1:0] KP_RESET      = 32'sd25166;
  localparam logic [GAIN_W-1:0] KI_RESET      = 32'sd1678;
  localparam logic [GAIN_W-1:0] KD_RESET      = 32'sd167772;
  localparam logic [LIM_W-1:0]  OUT_MAX_RESET = 9'sd255;
  localparam logic [LIM_W-1:0]  OUT_MIN_RESET = 9'sd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KD      = 3'd2,
    REG_OUT_MAX = 3'd3,
    REG_OUT_MIN = 3'd4
  } reg_idx_t;

  typedef enum logic {
    CMD_STEP  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [LIM_W-1:0] out_max;
    logic [LIM_W-1:0] out_min;
  } limits_t;

endpackage

// ----- rtl/pci_product.sv -----
// Product stage: error, measurement change and the three gain products.
// Holds the previous measurement. Depends on pci_pkg.
module pci_product import pci_pkg::*; #(
  parameter int MEAS_WIDTH = MEAS_WIDTH_DEF,
  parameter int PROD_W     = GAIN_W + MEAS_WIDTH_DEF + 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [MEAS_WIDTH-1:0]    in_meas,
  input  logic [MEAS_WIDTH-1:0]    in_setp,
  input  logic [GAIN_W-1:0]        kp_gain,
  input  logic [GAIN_W-1:0]        ki_gain,
  input  logic [GAIN_W-1:0]        kd_gain,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_cmd,
  output logic signed [PROD_W-1:0] out_pk,
  output logic signed [PROD_W-1:0] out_pi,
  output logic signed [PROD_W-1:0] out_pd
);

  localparam int ERR_W = MEAS_WIDTH + 1;

  logic [MEAS_WIDTH-1:0]    prev_measured;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  dmeas;
  logic signed [PROD_W-1:0] pk_next;
  logic signed [PROD_W-1:0] pi_next;
  logic signed [PROD_W-1:0] pd_next;
  logic                     load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  assign err   = ERR_W'($signed(in_setp)) - ERR_W'($signed(in_meas));
  assign dmeas = ERR_W'($signed(in_meas)) - ERR_W'($signed(prev_measured));

  assign pk_next = $signed(kp_gain) * err;
  assign pi_next = $signed(ki_gain) * err;
  assign pd_next = $signed(kd_gain) * dmeas;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      prev_measured <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        prev_measured <= (in_cmd == CMD_CLEAR) ? '0 : in_meas;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd <= in_cmd;
      out_pk  <= pk_next;
      out_pi  <= pi_next;
      out_pd  <= pd_next;
    end
  end

endmodule

// ----- rtl/pci_integrator.sv -----
// Integrator stage: clamped integral update and the proportional minus
// derivative difference. Depends on pci_pkg.
module pci_integrator import pci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int PROD_W    = GAIN_W + MEAS_WIDTH_DEF + 1,
  parameter int INT_W     = FRAC_BITS_DEF + LIM_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  limits_t                    lim,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic signed [PROD_W-1:0]   in_pk,
  input  logic signed [PROD_W-1:0]   in_pi,
  input  logic signed [PROD_W-1:0]   in_pd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_cmd,
  output logic signed [INT_W-1:0]    out_integ,
  output logic signed [PROD_W:0]     out_pdiff
);

  localparam int ACC_W = ((PROD_W > INT_W) ? PROD_W : INT_W) + 1;

  logic signed [INT_W-1:0] integral;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] hq;
  logic signed [ACC_W-1:0] lq;
  logic signed [ACC_W-1:0] acc_clamped;
  logic signed [INT_W-1:0] integral_next;
  logic                    load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  assign acc = ACC_W'(integral) + ACC_W'(in_pi);
  assign hq  = $signed({{(ACC_W-LIM_W){lim.out_max[LIM_W-1]}}, lim.out_max}) <<< FRAC_BITS;
  assign lq  = $signed({{(ACC_W-LIM_W){lim.out_min[LIM_W-1]}}, lim.out_min}) <<< FRAC_BITS;

  // With inverted limits the result is the upper limit if acc exceeds it, else the lower limit
  always_comb begin
    if (acc > hq) begin
      acc_clamped = hq;
    end else if (acc < lq) begin
      acc_clamped = lq;
    end else begin
      acc_clamped = acc;
    end
  end

  assign integral_next = (in_cmd == CMD_CLEAR) ? '0 : acc_clamped[INT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      integral  <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (load) begin
        integral <= integral_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_cmd   <= in_cmd;
      out_integ <= integral_next;
      out_pdiff <= (PROD_W+1)'(in_pk) - (PROD_W+1)'(in_pd);
    end
  end

`ifndef ASSERT_OFF
  a_clear_zeroes_integral: assert property (@(posedge clk) disable iff (rst)
    (load && in_cmd == CMD_CLEAR) |=> (integral == '0))
    else $error("integral not cleared by clear item");
  a_item_moves_on: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid)
    else $error("item lost in integrator stage");
`endif

endmodule

// ----- rtl/pci_output.sv -----
// Output stage: final sum, clamp, truncation toward zero and drive register.
// Depends on pci_pkg.
module pci_output import pci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int PROD_W    = GAIN_W + MEAS_WIDTH_DEF + 1,
  parameter int INT_W     = FRAC_BITS_DEF + LIM_W
) (
  input  logic                     clk,
  input  logic                     rst,
  input  limits_t                  lim,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic signed [INT_W-1:0]  in_integ,
  input  logic signed [PROD_W:0]   in_pdiff,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [LIM_W-1:0]         drive
);

  localparam int SUM_W = ((PROD_W + 1 > INT_W) ? PROD_W + 1 : INT_W) + 1;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] hq;
  logic signed [SUM_W-1:0] lq;
  logic signed [SUM_W-1:0] sum_clamped;
  logic signed [SUM_W-1:0] bias;
  logic signed [SUM_W-1:0] rounded;
  logic [LIM_W-1:0]        drive_next;
  logic                    load;

  assign in_ready = !out_valid || out_ready;
  assign load     = in_valid && in_ready;

  assign sum = SUM_W'(in_pdiff) + SUM_W'(in_integ);
  assign hq  = $signed({{(SUM_W-LIM_W){lim.out_max[LIM_W-1]}}, lim.out_max}) <<< FRAC_BITS;
  assign lq  = $signed({{(SUM_W-LIM_W){lim.out_min[LIM_W-1]}}, lim.out_min}) <<< FRAC_BITS;

  always_comb begin
    if (sum > hq) begin
      sum_clamped = hq;
    end else if (sum < lq) begin
      sum_clamped = lq;
    end else begin
      sum_clamped = sum;
    end
  end

  // Bias negative values so the arithmetic shift truncates toward zero
  assign bias    = sum_clamped[SUM_W-1] ? SUM_W'((64'sd1 <<< FRAC_BITS) - 64'sd1) : '0;
  assign rounded = sum_clamped + bias;

  assign drive_next = (in_cmd == CMD_CLEAR) ? lim.out_min
                                            : rounded[FRAC_BITS+LIM_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      drive <= drive_next;
    end
  end

`ifndef ASSERT_OFF
  a_clear_emits_min: assert property (@(posedge clk) disable iff (rst)
    (load && in_cmd == CMD_CLEAR) |=> (drive == $past(lim.out_min)))
    else $error("clear item did not emit the lower limit");
`endif

endmodule

// ----- rtl/pid_clamped_integral_top.sv -----
// PID controller with clamped integral (anti-windup): top level.
//
// Input channel (in_valid/in_stall): command, measured, setpoint. An item
// is taken at a clock edge with in_valid high and in_stall low. command
// CMD_STEP runs one control step; CMD_CLEAR zeroes the integral and the
// stored measurement and returns out_min as the drive.
// Output channel (out_valid/out_stall): one drive value per input item,
// in order. Configuration: cfg_we writes cfg_data to the register chosen
// by cfg_index (gains Q(32-FRAC_BITS).FRAC_BITS, then out_max, out_min); write only
// while no item is in flight.
// Pipeline: the input register loads at the accepting edge, then the
// multiply stage, integrator stage and drive register follow in order.
// Throughput: one item per cycle while out_stall is low; the integral
// loop closes within the integrator stage, one add and clamp per item.
// Reset (rst, synchronous): pipeline empty, integral and last measurement
// zero, registers back to their defaults. While out_stall is high the
// drive holds; stages fill behind it and in_stall rises only once every
// stage holds an item.
// Depends on pci_pkg, pci_product, pci_integrator and pci_output.
module pid_clamped_integral_top import pci_pkg::*; #(
  parameter int MEAS_WIDTH = MEAS_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [GAIN_W-1:0]     cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  command,
  input  logic [MEAS_WIDTH-1:0] measured,
  input  logic [MEAS_WIDTH-1:0] setpoint,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LIM_W-1:0]      drive
);

  localparam int PROD_W = GAIN_W + MEAS_WIDTH + 1;
  localparam int INT_W  = FRAC_BITS + LIM_W;

  logic [GAIN_W-1:0] kp_gain;
  logic [GAIN_W-1:0] ki_gain;
  logic [GAIN_W-1:0] kd_gain;
  limits_t           lim;

  logic                  s1_valid;
  logic                  s1_cmd;
  logic [MEAS_WIDTH-1:0] s1_meas;
  logic [MEAS_WIDTH-1:0] s1_setp;
  logic                  s1_ready;
  logic                  p_ready;
  logic                  in_load;

  logic                     s2_valid;
  logic                     s2_ready;
  logic                     s2_cmd;
  logic signed [PROD_W-1:0] s2_pk;
  logic signed [PROD_W-1:0] s2_pi;
  logic signed [PROD_W-1:0] s2_pd;

  logic                     s3_valid;
  logic                     s3_ready;
  logic                     s3_cmd;
  logic signed [INT_W-1:0]  s3_integ;
  logic signed [PROD_W:0]   s3_pdiff;

  logic                     s4_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain     <= KP_RESET;
      ki_gain     <= KI_RESET;
      kd_gain     <= KD_RESET;
      lim.out_max <= OUT_MAX_RESET;
      lim.out_min <= OUT_MIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:      kp_gain     <= cfg_data;
        REG_KI:      ki_gain     <= cfg_data;
        REG_KD:      kd_gain     <= cfg_data;
        REG_OUT_MAX: lim.out_max <= cfg_data[LIM_W-1:0];
        REG_OUT_MIN: lim.out_min <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: take a new item when empty or when its item moves on
  assign s1_ready = !s1_valid || p_ready;
  assign in_stall = !s1_ready;
  assign in_load  = in_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_cmd  <= command;
      s1_meas <= measured;
      s1_setp <= setpoint;
    end
  end

  pci_product #(
    .MEAS_WIDTH (MEAS_WIDTH),
    .PROD_W     (PROD_W)
  ) u_product (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (p_ready),
    .in_cmd    (s1_cmd),
    .in_meas   (s1_meas),
    .in_setp   (s1_setp),
    .kp_gain   (kp_gain),
    .ki_gain   (ki_gain),
    .kd_gain   (kd_gain),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_cmd   (s2_cmd),
    .out_pk    (s2_pk),
    .out_pi    (s2_pi),
    .out_pd    (s2_pd)
  );

  pci_integrator #(
    .FRAC_BITS (FRAC_BITS),
    .PROD_W    (PROD_W),
    .INT_W     (INT_W)
  ) u_integrator (
    .clk       (clk),
    .rst       (rst),
    .lim       (lim),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_cmd    (s2_cmd),
    .in_pk     (s2_pk),
    .in_pi     (s2_pi),
    .in_pd     (s2_pd),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_cmd   (s3_cmd),
    .out_integ (s3_integ),
    .out_pdiff (s3_pdiff)
  );

  pci_output #(
    .FRAC_BITS (FRAC_BITS),
    .PROD_W    (PROD_W),
    .INT_W     (INT_W)
  ) u_output (
    .clk       (clk),
    .rst       (rst),
    .lim       (lim),
    .in_valid  (s3_valid),
    .in_ready  (s3_ready),
    .in_cmd    (s3_cmd),
    .in_integ  (s3_integ),
    .in_pdiff  (s3_pdiff),
    .out_valid (out_valid),
    .out_ready (s4_ready),
    .drive     (drive)
  );

  assign s4_ready = !out_stall;

`ifndef ASSERT_OFF
  a_empty_input_takes: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("input stalled with an empty input register");
  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule
